// ===== rtl/eep_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eep_pkg
// Shared types and constants of the expiring entry pool.
// ----------------------------------------------------------------------------
package eep_pkg;

   localparam int POOL_DEPTH = 64;
   localparam int IDX_W      = $clog2(POOL_DEPTH);
   localparam int PTR_W      = $clog2(POOL_DEPTH + 1);
   localparam logic [PTR_W-1:0] END_MARK = PTR_W'(POOL_DEPTH);

   localparam int RSP_IDX_W = 6;
   localparam int RSP_CNT_W = 7;
   localparam int RSV_W     = 7;

   typedef enum logic [2:0] {
      OP_INIT   = 3'd0,
      OP_INSERT = 3'd1,
      OP_KEYED  = 3'd2,
      OP_SWEEP  = 3'd3,
      OP_QUERY  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_NONE = 2'd2
   } rsp_code_type;

   typedef enum logic [1:0] {
      IDX_ZERO = 2'd0,
      IDX_NODE = 2'd1,
      IDX_BEST = 2'd2
   } idx_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_KEY_RD,
      S_KEY_EV,
      S_TAKE_RD,
      S_TAKE_WR,
      S_FILL,
      S_SWP_RD,
      S_SWP_EV,
      S_SWP_FREE,
      S_QRY_RD,
      S_QRY_MUL,
      S_QRY_CMP,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [15:0] snd_type;
      logic [15:0] px;
      logic [15:0] py;
      logic [15:0] pz;
      logic [15:0] vol;
      logic [31:0] expiry;
      logic        never;
      logic [15:0] owner;
   } entry_word_type;

   typedef struct packed {
      logic         latch_req;
      logic         init_step;
      logic         init_done;
      logic         start_walk;
      logic         rd_cur;
      logic         rd_free;
      logic         advance;
      logic         unlink;
      logic         release_node;
      logic         take;
      logic         mul;
      logic         cmp;
      logic         select_cur;
      logic         fill;
      logic         keyed;
      logic         load_rsp;
      rsp_code_type rsp_status;
      idx_sel_type  rsp_idx_sel;
   } eep_cmd_type;

   typedef struct packed {
      logic cur_end;
      logic free_empty;
      logic match;
      logic expire;
      logic init_last;
      logic reserve_over;
      logic best_found;
   } eep_stat_type;

endpackage
`default_nettype wire

// ===== rtl/eep_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eep_ctrl
// Operation sequencer: walks the lists one node at a time and issues
// commands to the datapath.
// ----------------------------------------------------------------------------
module eep_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire  [2:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   input  eep_pkg::eep_stat_type stat,
   output eep_pkg::eep_cmd_type  cmd
);

   eep_pkg::state_type    state_ff, state_in;
   logic [2:0]            op_ff, op_in;
   logic                  silent_ff, silent_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   eep_pkg::rsp_code_type res_status_ff, res_status_in;
   eep_pkg::idx_sel_type  res_sel_ff, res_sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= eep_pkg::S_INIT;
         op_ff         <= eep_pkg::OP_INIT;
         silent_ff     <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         res_status_ff <= eep_pkg::ST_OK;
         res_sel_ff    <= eep_pkg::IDX_ZERO;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         silent_ff     <= silent_in;
         rsp_valid_ff  <= rsp_valid_in;
         res_status_ff <= res_status_in;
         res_sel_ff    <= res_sel_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      silent_in     = silent_ff;
      res_status_in = res_status_ff;
      res_sel_in    = res_sel_ff;
      cmd           = '0;
      cmd.keyed     = (op_ff == eep_pkg::OP_KEYED);
      cmd.rsp_status  = res_status_ff;
      cmd.rsp_idx_sel = res_sel_ff;
      req_tready    = 1'b0;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;

      unique case (state_ff)
         eep_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               op_in         = req_tuser;
               res_status_in = eep_pkg::ST_OK;
               res_sel_in    = eep_pkg::IDX_ZERO;
               case (req_tuser)
                  eep_pkg::OP_INIT:   state_in = eep_pkg::S_INIT;
                  eep_pkg::OP_INSERT: state_in = eep_pkg::S_TAKE_RD;
                  eep_pkg::OP_KEYED: begin
                     cmd.start_walk = 1'b1;
                     state_in       = eep_pkg::S_KEY_RD;
                  end
                  eep_pkg::OP_SWEEP: begin
                     cmd.start_walk = 1'b1;
                     state_in       = eep_pkg::S_SWP_RD;
                  end
                  eep_pkg::OP_QUERY: begin
                     cmd.start_walk = 1'b1;
                     state_in       = eep_pkg::S_QRY_RD;
                  end
                  default: state_in = eep_pkg::S_RESP;
               endcase
            end
         end
         eep_pkg::S_INIT: begin
            cmd.init_step = 1'b1;
            if (stat.init_last) begin
               cmd.init_done = 1'b1;
               res_status_in = stat.reserve_over ? eep_pkg::ST_FULL : eep_pkg::ST_OK;
               res_sel_in    = eep_pkg::IDX_ZERO;
               state_in      = eep_pkg::S_RESP;
            end
         end
         eep_pkg::S_KEY_RD: begin
            if (stat.cur_end) begin
               state_in = eep_pkg::S_TAKE_RD;
            end else begin
               cmd.rd_cur = 1'b1;
               state_in   = eep_pkg::S_KEY_EV;
            end
         end
         eep_pkg::S_KEY_EV: begin
            if (stat.match) begin
               cmd.select_cur = 1'b1;
               state_in       = eep_pkg::S_FILL;
            end else begin
               cmd.advance = 1'b1;
               state_in    = eep_pkg::S_KEY_RD;
            end
         end
         eep_pkg::S_TAKE_RD: begin
            if (stat.free_empty) begin
               res_status_in = eep_pkg::ST_FULL;
               res_sel_in    = eep_pkg::IDX_ZERO;
               state_in      = eep_pkg::S_RESP;
            end else begin
               cmd.rd_free = 1'b1;
               state_in    = eep_pkg::S_TAKE_WR;
            end
         end
         eep_pkg::S_TAKE_WR: begin
            cmd.take = 1'b1;
            state_in = eep_pkg::S_FILL;
         end
         eep_pkg::S_FILL: begin
            cmd.fill      = 1'b1;
            res_status_in = eep_pkg::ST_OK;
            res_sel_in    = eep_pkg::IDX_NODE;
            state_in      = eep_pkg::S_RESP;
         end
         eep_pkg::S_SWP_RD: begin
            if (stat.cur_end) begin
               state_in = eep_pkg::S_RESP;
            end else begin
               cmd.rd_cur = 1'b1;
               state_in   = eep_pkg::S_SWP_EV;
            end
         end
         eep_pkg::S_SWP_EV: begin
            if (stat.expire) begin
               cmd.unlink = 1'b1;
               state_in   = eep_pkg::S_SWP_FREE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = eep_pkg::S_SWP_RD;
            end
         end
         eep_pkg::S_SWP_FREE: begin
            cmd.release_node = 1'b1;
            state_in         = eep_pkg::S_SWP_RD;
         end
         eep_pkg::S_QRY_RD: begin
            if (stat.cur_end) begin
               res_status_in = stat.best_found ? eep_pkg::ST_OK : eep_pkg::ST_NONE;
               res_sel_in    = stat.best_found ? eep_pkg::IDX_BEST : eep_pkg::IDX_ZERO;
               state_in      = eep_pkg::S_RESP;
            end else begin
               cmd.rd_cur = 1'b1;
               state_in   = eep_pkg::S_QRY_MUL;
            end
         end
         eep_pkg::S_QRY_MUL: begin
            cmd.mul  = 1'b1;
            state_in = eep_pkg::S_QRY_CMP;
         end
         eep_pkg::S_QRY_CMP: begin
            cmd.cmp     = 1'b1;
            cmd.advance = 1'b1;
            state_in    = eep_pkg::S_QRY_RD;
         end
         eep_pkg::S_RESP: begin
            if (silent_ff) begin
               // The pass that follows reset rebuilds the pool without a word.
               silent_in = 1'b0;
               state_in  = eep_pkg::S_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = eep_pkg::S_IDLE;
            end
         end
         default: state_in = eep_pkg::S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/eep_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eep_datapath
// Entry and link memories, list pointers, distance unit and result register.
// ----------------------------------------------------------------------------
module eep_datapath (
   input  wire                          clock,
   input  wire                          reset,
   input  eep_pkg::eep_cmd_type         cmd,
   output eep_pkg::eep_stat_type        stat,
   input  wire  [eep_pkg::RSV_W-1:0]    reserved_count,
   input  wire  [151:0]                 req_tdata,
   output logic [1:0]                   rsp_status,
   output logic [eep_pkg::RSP_IDX_W-1:0] rsp_index,
   output logic [eep_pkg::RSP_CNT_W-1:0] rsp_total
);

   localparam int PW = eep_pkg::PTR_W;
   localparam int IW = eep_pkg::IDX_W;

   // Latched request fields.
   logic [15:0] q_type_ff, q_px_ff, q_py_ff, q_pz_ff, q_vol_ff, q_dur_ff, q_owner_ff;
   logic [7:0]  q_chan_ff;
   logic [31:0] q_now_ff;

   // Memories.
   logic [PW-1:0]                link_mem [eep_pkg::POOL_DEPTH];
   eep_pkg::entry_word_type      entry_mem [eep_pkg::POOL_DEPTH];
   logic [7:0]                   chan_mem [eep_pkg::POOL_DEPTH];
   logic [PW-1:0]                link_rd_ff;
   eep_pkg::entry_word_type      entry_rd_ff;
   logic [7:0]                   chan_rd_ff;

   // List state.
   logic [PW-1:0] cur_ff, prev_ff, node_ff, free_head_ff, active_head_ff;
   logic [PW-1:0] count_ff;
   logic [IW-1:0] init_idx_ff;
   logic [35:0]   best_ff;
   logic [PW-1:0] best_idx_ff;
   logic [33:0]   sqx_ff, sqy_ff, sqz_ff;
   logic [31:0]   vsq_ff;
   logic          tmatch_ff;

   // Reserve amount clipped to the pool.
   logic          over;
   logic [PW-1:0] rsv;
   assign over = 32'(reserved_count) > 32'(eep_pkg::POOL_DEPTH);
   assign rsv  = over ? eep_pkg::END_MARK : PW'(reserved_count);

   logic [PW-1:0] init_ptr;
   assign init_ptr = PW'(init_idx_ff);

   // Link memory write port.
   logic          link_we;
   logic [IW-1:0] link_wa;
   logic [PW-1:0] link_wd;

   always_comb begin
      link_we = 1'b0;
      link_wa = '0;
      link_wd = '0;
      if (cmd.init_step) begin
         link_we = 1'b1;
         link_wa = init_idx_ff;
         if (init_ptr < rsv)
            link_wd = (init_idx_ff == '0) ? eep_pkg::END_MARK : init_ptr - PW'(1);
         else
            link_wd = init_ptr + PW'(1);
      end else if (cmd.unlink && prev_ff != eep_pkg::END_MARK) begin
         link_we = 1'b1;
         link_wa = prev_ff[IW-1:0];
         link_wd = link_rd_ff;
      end else if (cmd.release_node) begin
         link_we = 1'b1;
         link_wa = node_ff[IW-1:0];
         link_wd = free_head_ff;
      end else if (cmd.take) begin
         link_we = 1'b1;
         link_wa = free_head_ff[IW-1:0];
         link_wd = active_head_ff;
      end
   end

   // Entry write data.
   logic [32:0]             exp_sum;
   eep_pkg::entry_word_type fill_word, init_word;
   assign exp_sum = {1'b0, q_now_ff} + 33'(q_dur_ff);

   always_comb begin
      fill_word.snd_type = q_type_ff;
      fill_word.px       = q_px_ff;
      fill_word.py       = q_py_ff;
      fill_word.pz       = q_pz_ff;
      fill_word.vol      = q_vol_ff;
      fill_word.expiry   = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
      fill_word.never    = 1'b0;
      fill_word.owner    = cmd.keyed ? q_owner_ff : 16'd0;
      init_word          = '0;
      init_word.never    = (init_ptr < rsv);
   end

   logic          rd_en;
   logic [IW-1:0] rd_addr;
   assign rd_en   = cmd.rd_cur | cmd.rd_free;
   assign rd_addr = cmd.rd_free ? free_head_ff[IW-1:0] : cur_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (link_we)
         link_mem[link_wa] <= link_wd;
      if (cmd.init_step) begin
         entry_mem[init_idx_ff] <= init_word;
         chan_mem[init_idx_ff]  <= 8'd0;
      end else if (cmd.fill) begin
         entry_mem[node_ff[IW-1:0]] <= fill_word;
         if (cmd.keyed)
            chan_mem[node_ff[IW-1:0]] <= q_chan_ff;
      end
      if (rd_en) begin
         link_rd_ff  <= link_mem[rd_addr];
         entry_rd_ff <= entry_mem[rd_addr];
         chan_rd_ff  <= chan_mem[rd_addr];
      end
   end

   // Squared distance terms, registered before the sum.
   logic signed [16:0] dx, dy, dz;
   logic signed [33:0] dx2, dy2, dz2;
   logic [31:0]        v2;
   logic [35:0]        d2;
   assign dx  = {entry_rd_ff.px[15], entry_rd_ff.px} - {q_px_ff[15], q_px_ff};
   assign dy  = {entry_rd_ff.py[15], entry_rd_ff.py} - {q_py_ff[15], q_py_ff};
   assign dz  = {entry_rd_ff.pz[15], entry_rd_ff.pz} - {q_pz_ff[15], q_pz_ff};
   assign dx2 = dx * dx;
   assign dy2 = dy * dy;
   assign dz2 = dz * dz;
   assign v2  = entry_rd_ff.vol * entry_rd_ff.vol;
   assign d2  = 36'(sqx_ff) + 36'(sqy_ff) + 36'(sqz_ff);

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         q_type_ff  <= req_tdata[15:0];
         q_px_ff    <= req_tdata[31:16];
         q_py_ff    <= req_tdata[47:32];
         q_pz_ff    <= req_tdata[63:48];
         q_vol_ff   <= req_tdata[79:64];
         q_dur_ff   <= req_tdata[95:80];
         q_owner_ff <= req_tdata[111:96];
         q_chan_ff  <= req_tdata[119:112];
         q_now_ff   <= req_tdata[151:120];
      end
      if (cmd.mul) begin
         sqx_ff    <= $unsigned(dx2);
         sqy_ff    <= $unsigned(dy2);
         sqz_ff    <= $unsigned(dz2);
         vsq_ff    <= v2;
         tmatch_ff <= (entry_rd_ff.snd_type == q_type_ff);
      end
      if (cmd.start_walk) begin
         best_ff     <= '1;
         best_idx_ff <= eep_pkg::END_MARK;
      end else if (cmd.cmp && tmatch_ff && d2 <= 36'(vsq_ff) && d2 < best_ff) begin
         best_ff     <= d2;
         best_idx_ff <= cur_ff;
      end
      if (cmd.load_rsp) begin
         rsp_status <= cmd.rsp_status;
         rsp_total  <= eep_pkg::RSP_CNT_W'(count_ff);
         case (cmd.rsp_idx_sel)
            eep_pkg::IDX_NODE: rsp_index <= eep_pkg::RSP_IDX_W'(node_ff);
            eep_pkg::IDX_BEST: rsp_index <= eep_pkg::RSP_IDX_W'(best_idx_ff);
            default:           rsp_index <= '0;
         endcase
      end
   end

   // List pointers and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff         <= eep_pkg::END_MARK;
         prev_ff        <= eep_pkg::END_MARK;
         node_ff        <= '0;
         free_head_ff   <= '0;
         active_head_ff <= eep_pkg::END_MARK;
         count_ff       <= '0;
         init_idx_ff    <= '0;
      end else begin
         if (cmd.latch_req)
            init_idx_ff <= '0;
         else if (cmd.init_step)
            init_idx_ff <= init_idx_ff + IW'(1);
         if (cmd.init_done) begin
            free_head_ff   <= rsv;
            active_head_ff <= (rsv == '0) ? eep_pkg::END_MARK : rsv - PW'(1);
            count_ff       <= rsv;
         end
         if (cmd.start_walk) begin
            cur_ff  <= active_head_ff;
            prev_ff <= eep_pkg::END_MARK;
         end
         if (cmd.advance) begin
            prev_ff <= cur_ff;
            cur_ff  <= link_rd_ff;
         end
         if (cmd.unlink) begin
            if (prev_ff == eep_pkg::END_MARK)
               active_head_ff <= link_rd_ff;
            node_ff <= cur_ff;
            cur_ff  <= link_rd_ff;
         end
         if (cmd.release_node) begin
            free_head_ff <= node_ff;
            count_ff     <= count_ff - PW'(1);
         end
         if (cmd.take) begin
            free_head_ff   <= link_rd_ff;
            active_head_ff <= free_head_ff;
            count_ff       <= count_ff + PW'(1);
            node_ff        <= free_head_ff;
         end
         if (cmd.select_cur)
            node_ff <= cur_ff;
      end
   end

   always_comb begin
      stat.cur_end      = (cur_ff == eep_pkg::END_MARK);
      stat.free_empty   = (free_head_ff == eep_pkg::END_MARK);
      stat.match        = (entry_rd_ff.owner == q_owner_ff) && (chan_rd_ff == q_chan_ff);
      stat.expire       = !entry_rd_ff.never && (entry_rd_ff.expiry <= q_now_ff);
      stat.init_last    = (init_idx_ff == IW'(eep_pkg::POOL_DEPTH - 1));
      stat.reserve_over = over;
      stat.best_found   = (best_idx_ff != eep_pkg::END_MARK);
   end

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= PW'(eep_pkg::POOL_DEPTH))
      else $error("active count above pool depth");

   a_empty_head : assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> active_head_ff == eep_pkg::END_MARK)
      else $error("empty pool with an active head");

   a_free_empty : assert property (@(posedge clock) disable iff (reset)
      free_head_ff == eep_pkg::END_MARK |-> count_ff == PW'(eep_pkg::POOL_DEPTH))
      else $error("free list empty while pool not full");

endmodule
`default_nettype wire

// ===== rtl/expiring_entry_pool.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// expiring_entry_pool
// Fixed pool of event entries on linked free and active lists, with timed
// expiry, keyed reuse and nearest-entry query.
// ----------------------------------------------------------------------------
// A keyed insert walks the active list and reuses the first entry whose
// owner and channel match, else it takes from the free list as a plain
// insert does; a sweep walks every active entry and frees the expired
// ones; a query walks every active entry. One word is in flight at a time;
// each linked node costs one registered read of the entry memory before it
// can be judged, and the next word is taken once the response is loaded.
// Reset: the controller runs the init pass with one reserved entry
// (req_tready low) and gives no response word for it.
// ----------------------------------------------------------------------------
module expiring_entry_pool (
   input  wire         clock,
   input  wire         reset,
   // Request channel.
   input  wire         req_tvalid,
   output logic        req_tready,
   // sound_type[15:0], pos_x[31:16], pos_y[47:32], pos_z[63:48],
   // volume[79:64], duration[95:80], owner_id[111:96], channel[119:112],
   // current_time[151:120]
   input  wire  [151:0] req_tdata,
   // operation[2:0]
   input  wire  [2:0]  req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // entry_index[5:0], active_total[12:6], zero fill above
   output logic [15:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser,
   // Register port.
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   eep_pkg::eep_cmd_type  cmd;
   eep_pkg::eep_stat_type stat;

   // The reserved count register answers at addresses zero to three; addresses
   // four to seven read as zero and ignore writes.
   logic [eep_pkg::RSV_W-1:0] rsv_ff, rsv_in;
   logic                      csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & ~csr_paddr[2];
   assign rsv_in     = csr_wr ? csr_pwdata[eep_pkg::RSV_W-1:0] : rsv_ff;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : 32'(rsv_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsv_ff <= eep_pkg::RSV_W'(1);
      end else begin
         rsv_ff <= rsv_in;
      end
   end

   logic [eep_pkg::RSP_IDX_W-1:0] rsp_index;
   logic [eep_pkg::RSP_CNT_W-1:0] rsp_total;

   // Response word: index in the low bits, total above, padded to 16 bits.
   assign rsp_tdata = {3'd0, rsp_total, rsp_index};

   eep_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   eep_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .reserved_count (rsv_ff),
      .req_tdata      (req_tdata),
      .rsp_status     (rsp_tuser),
      .rsp_index      (rsp_index),
      .rsp_total      (rsp_total)
   );

endmodule
`default_nettype wire

// ===== dv/expiring_entry_pool_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expiring_entry_pool_tb
// Self-checking bench for the expiring entry pool. A queue of request words
// feeds a clocked driver, and an in-bench pool model predicts one response
// word per accepted request. A monitor compares every response field by
// field. Phases change the reserved count over the register port and vary
// the idle pattern of both stream sides.
// ----------------------------------------------------------------------------
module expiring_entry_pool_tb;

   localparam logic [2:0] RSV_ADDR = 3'd0;
   localparam int         DEPTH    = 64;
   localparam logic [6:0] NIL      = 7'd64;

   // One request word as the bench sees it. Setting wait_drain holds the
   // word back until every outstanding response has come back.
   typedef struct {
      logic [2:0]  op;
      logic [15:0] stype;
      logic [15:0] px;
      logic [15:0] py;
      logic [15:0] pz;
      logic [15:0] vol;
      logic [15:0] dur;
      logic [15:0] owner;
      logic [7:0]  chan;
      logic [31:0] now;
      bit          wait_drain;
   } pool_req_type;

   typedef struct {
      logic [1:0] status;
      logic [5:0] index;
      logic [6:0] total;
   } pool_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [151:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [15:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   expiring_entry_pool dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   pool_req_type pending_words[$];
   pool_rsp_type expected_rsps[$];
   int          error_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          req_taken = 1'b0;
   logic [31:0] tick_now = 32'd1000;

   // Shadow copy of the pool: links, list heads, entry fields and count.
   logic [6:0]  shadow_rsv = 7'd1;
   logic [6:0]  link_q[DEPTH];
   logic [6:0]  free_top;
   logic [6:0]  live_top;
   logic [15:0] ent_type[DEPTH];
   logic [15:0] ent_x[DEPTH];
   logic [15:0] ent_y[DEPTH];
   logic [15:0] ent_z[DEPTH];
   logic [15:0] ent_vol[DEPTH];
   logic [31:0] ent_expiry[DEPTH];
   bit          ent_pinned[DEPTH];
   logic [15:0] ent_owner[DEPTH];
   logic [7:0]  ent_chan[DEPTH];
   int unsigned live_count;

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Move the free head onto the live list; NIL when no entry is free.
   function automatic logic [6:0] claim_free();
      logic [6:0] n;
      n = free_top;
      if (n >= NIL) return NIL;
      free_top = link_q[n];
      link_q[n] = live_top;
      live_top = n;
      live_count++;
      return n;
   endfunction

   // Rebuild the pool; returns 0 when the reserve asked for exceeds the pool.
   function automatic bit rebuild_pool();
      logic [6:0] n;
      for (int i = 0; i < DEPTH; i++) begin
         link_q[i] = 7'(i + 1);
         ent_type[i] = '0; ent_x[i] = '0; ent_y[i] = '0; ent_z[i] = '0;
         ent_vol[i] = '0; ent_expiry[i] = '0; ent_pinned[i] = 1'b0;
         ent_owner[i] = '0; ent_chan[i] = '0;
      end
      free_top = '0;
      live_top = NIL;
      live_count = 0;
      for (int i = 0; i < shadow_rsv; i++) begin
         n = claim_free();
         if (n >= NIL) return 1'b0;
         ent_pinned[n] = 1'b1;
      end
      return 1'b1;
   endfunction

   // Apply one request to the shadow pool and return the response it gives.
   function automatic pool_rsp_type apply_request(input pool_req_type r);
      pool_rsp_type rs;
      logic [6:0]  cur, prv, nxt, hit;
      logic [32:0] sum;
      longint      dx, dy, dz;
      longint unsigned d2, best, reach;
      rs.status = eep_pkg::ST_OK;
      rs.index = '0;
      if (r.op == eep_pkg::OP_INIT) begin
         if (!rebuild_pool()) rs.status = eep_pkg::ST_FULL;
      end else if (r.op == eep_pkg::OP_INSERT || r.op == eep_pkg::OP_KEYED) begin
         hit = NIL;
         if (r.op == eep_pkg::OP_KEYED) begin
            cur = live_top;
            for (int s = 0; s < DEPTH && cur < NIL; s++) begin
               if (ent_owner[cur] == r.owner && ent_chan[cur] == r.chan) begin
                  hit = cur;
                  break;
               end
               cur = link_q[cur];
            end
         end
         if (hit >= NIL) hit = claim_free();
         if (hit >= NIL) begin
            rs.status = eep_pkg::ST_FULL;
         end else begin
            // Expiry saturates instead of wrapping.
            sum = {1'b0, r.now} + r.dur;
            ent_expiry[hit] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            ent_type[hit] = r.stype;
            ent_x[hit] = r.px; ent_y[hit] = r.py; ent_z[hit] = r.pz;
            ent_vol[hit] = r.vol;
            ent_pinned[hit] = 1'b0;
            ent_owner[hit] = (r.op == eep_pkg::OP_KEYED) ? r.owner : 16'd0;
            if (r.op == eep_pkg::OP_KEYED) ent_chan[hit] = r.chan;
            rs.index = hit[5:0];
         end
      end else if (r.op == eep_pkg::OP_SWEEP) begin
         prv = NIL;
         cur = live_top;
         for (int s = 0; s < DEPTH && cur < NIL; s++) begin
            nxt = link_q[cur];
            if (!ent_pinned[cur] && ent_expiry[cur] <= r.now) begin
               if (prv < NIL) link_q[prv] = nxt;
               else live_top = nxt;
               link_q[cur] = free_top;
               free_top = cur;
               if (live_count > 0) live_count--;
            end else begin
               prv = cur;
            end
            cur = nxt;
         end
      end else if (r.op == eep_pkg::OP_QUERY) begin
         best = 64'hFFFF_FFFF_FFFF_FFFF;
         hit = NIL;
         cur = live_top;
         for (int s = 0; s < DEPTH && cur < NIL; s++) begin
            if (ent_type[cur] == r.stype) begin
               dx = longint'($signed(ent_x[cur])) - longint'($signed(r.px));
               dy = longint'($signed(ent_y[cur])) - longint'($signed(r.py));
               dz = longint'($signed(ent_z[cur])) - longint'($signed(r.pz));
               d2 = dx * dx + dy * dy + dz * dz;
               reach = longint'(ent_vol[cur]) * longint'(ent_vol[cur]);
               // Strictly closer only, so the first in list order wins ties.
               if (d2 <= reach && d2 < best) begin
                  best = d2;
                  hit = cur;
               end
            end
            cur = link_q[cur];
         end
         if (hit < NIL) rs.index = hit[5:0];
         else rs.status = eep_pkg::ST_NONE;
      end
      rs.total = 7'(live_count);
      return rs;
   endfunction

   function automatic pool_req_type make_req(input logic [2:0] op, input int stype,
         input int px, input int py, input int pz, input int vol, input int dur,
         input int owner, input int chan, input logic [31:0] now);
      pool_req_type r;
      r.op = op; r.stype = 16'(stype);
      r.px = 16'(px); r.py = 16'(py); r.pz = 16'(pz);
      r.vol = 16'(vol); r.dur = 16'(dur); r.owner = 16'(owner);
      r.chan = 8'(chan); r.now = now; r.wait_drain = 1'b0;
      return r;
   endfunction

   // Mostly well-formed traffic on a small set of types, owners and positions
   // with time moving forward, plus some words with every field random.
   function automatic pool_req_type random_req();
      pool_req_type r;
      int unsigned pick;
      tick_now = tick_now + $urandom_range(0, 30);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 8) begin
         r = make_req(3'($urandom), $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom);
         return r;
      end
      r = make_req(eep_pkg::OP_QUERY, $urandom_range(0, 3),
                   int'($urandom_range(0, 200)) - 100,
                   int'($urandom_range(0, 200)) - 100, int'($urandom_range(0, 200)) - 100,
                   $urandom_range(0, 150), $urandom_range(0, 400), $urandom_range(0, 3),
                   int'($urandom_range(0, 2)) - 1, tick_now);
      if (pick < 2) r.op = eep_pkg::OP_INIT;
      else if (pick < 37) r.op = eep_pkg::OP_INSERT;
      else if (pick < 57) r.op = eep_pkg::OP_KEYED;
      else if (pick < 72) r.op = eep_pkg::OP_SWEEP;
      else if (pick < 99) r.op = eep_pkg::OP_QUERY;
      else r.op = 3'($urandom_range(5, 7));
      return r;
   endfunction

   // Drive side: request words and response back-pressure change on the
   // falling edge. A word is replaced only after the rising edge took it.
   always @(negedge clock) begin : drive_req
      pool_req_type r;
      if (!reset && (!req_tvalid || req_taken)) begin
         if (pending_words.size() > 0 &&
             (!pending_words[0].wait_drain || expected_rsps.size() == 0) &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            r = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {r.now, r.chan, r.owner, r.dur, r.vol, r.pz, r.py, r.px, r.stype};
            req_tuser <= r.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Sample side: predict on each accepted request, check each response.
   always @(posedge clock) begin : watch_bus
      pool_req_type r;
      pool_rsp_type want;
      req_taken = req_tvalid && req_tready && !reset;
      if (req_taken) begin
         r.op = req_tuser;
         {r.now, r.chan, r.owner, r.dur, r.vol, r.pz, r.py, r.px, r.stype} = req_tdata;
         expected_rsps.push_back(apply_request(r));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response word", rsp_tdata, -1);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_tuser != want.status)
               report_mismatch("status", rsp_tuser, want.status);
            if (rsp_tdata[5:0] != want.index)
               report_mismatch("entry_index", rsp_tdata[5:0], want.index);
            if (rsp_tdata[12:6] != want.total)
               report_mismatch("active_total", rsp_tdata[12:6], want.total);
         end
      end
   end

   task automatic settle();
      do @(posedge clock);
      while (pending_words.size() != 0 || expected_rsps.size() != 0 || req_tvalid);
      repeat (8) @(negedge clock);
   endtask

   // Register write followed by a read-back, then a fresh init so the new
   // reserve takes effect.
   task automatic set_reserve(input logic [6:0] value);
      @(negedge clock);
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_penable = 1'b0;
      csr_paddr = RSV_ADDR; csr_pwdata = {25'd0, value};
      @(negedge clock) csr_penable = 1'b1;
      @(negedge clock);
      csr_pwrite = 1'b0; csr_penable = 1'b0;
      shadow_rsv = value;
      @(negedge clock) csr_penable = 1'b1;
      @(posedge clock);
      if (csr_prdata[6:0] != value) report_mismatch("reserved_count readback",
                                                    csr_prdata[6:0], value);
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0;
      pending_words.push_back(make_req(eep_pkg::OP_INIT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic random_phase(input int count);
      repeat (count) pending_words.push_back(random_req());
      settle();
   endtask

   initial begin : stimulus
      pool_req_type r;
      void'(rebuild_pool());
      repeat (12) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // Directed part, starting from the reset state with one pinned entry.
      send_idle_pct = 31; recv_idle_pct = 59;
      pending_words.push_back(make_req(eep_pkg::OP_INSERT, 5, 0, 0, 0, 10, 100, 9, 3,
                              1000));
      pending_words.push_back(make_req(eep_pkg::OP_INSERT, 16'hFFFF, 32767, -32768,
                              -32768, 16'hFFFF, 16'hFFFF, 0, 0, 32'hFFFF_FFF0));
      pending_words.push_back(make_req(eep_pkg::OP_QUERY, 5, 3, 4, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(make_req(eep_pkg::OP_QUERY, 16'hFFFF, -32768, 32767, 32767,
                              0, 0, 0, 0, 0));
      pending_words.push_back(make_req(eep_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(make_req(eep_pkg::OP_QUERY, 9, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(make_req(eep_pkg::OP_KEYED, 1, 1, 1, 1, 5, 50, 0, 0, 1000));
      pending_words.push_back(make_req(eep_pkg::OP_KEYED, 2, -1, -1, -1, 9, 50, 16'hFFFF,
                              -128, 1000));
      pending_words.push_back(make_req(eep_pkg::OP_KEYED, 2, -2, -2, -2, 9, 60, 16'hFFFF,
                              -128, 1000));
      pending_words.push_back(make_req(eep_pkg::OP_KEYED, 3, 7, 7, 7, 9, 60, 16'hFFFF,
                              127, 1000));
      // Two entries at the same spot: the tie goes to the one nearer the head.
      pending_words.push_back(make_req(eep_pkg::OP_INSERT, 7, 20, 20, 20, 30, 500, 0, 0,
                              1000));
      pending_words.push_back(make_req(eep_pkg::OP_INSERT, 7, 20, 20, 20, 30, 500, 0, 0,
                              1000));
      pending_words.push_back(make_req(eep_pkg::OP_QUERY, 7, 25, 20, 20, 0, 0, 0, 0, 0));
      pending_words.push_back(make_req(eep_pkg::OP_SWEEP, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      r = make_req(eep_pkg::OP_SWEEP, 0, 0, 0, 0, 0, 0, 0, 0, 1100);
      r.wait_drain = 1'b1;
      pending_words.push_back(r);
      pending_words.push_back(make_req(3'd5, 1, 1, 1, 1, 1, 1, 1, 1, 1));
      pending_words.push_back(make_req(3'd6, 1, 1, 1, 1, 1, 1, 1, 1, 1));
      pending_words.push_back(make_req(3'd7, 1, 1, 1, 1, 1, 1, 1, 1, 1));
      pending_words.push_back(make_req(eep_pkg::OP_SWEEP, 0, 0, 0, 0, 0, 0, 0, 0,
                              32'hFFFF_FFFF));
      pending_words.push_back(make_req(eep_pkg::OP_INIT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      settle();

      // Random phases across reserve settings, including an empty reserve,
      // a full pool and a reserve larger than the pool.
      set_reserve(7'd0);
      random_phase(380);
      set_reserve(7'd64);
      random_phase(25);
      send_idle_pct = 59; recv_idle_pct = 31;
      set_reserve(7'd127);
      random_phase(25);
      set_reserve(7'd3);
      random_phase(330);
      send_idle_pct = 0; recv_idle_pct = 0;
      set_reserve(7'd65);
      random_phase(20);
      set_reserve(7'd2);
      random_phase(350);

      repeat (300) @(posedge clock);
      if (expected_rsps.size() != 0)
         report_mismatch("responses never delivered", 0, expected_rsps.size());
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : run_limit
      #15ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
